>>> design/mec_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Mandelbrot escape-time colour block.
// No dependencies; every module of the block imports this package.
package mec_pkg;

  // Fixed-point format of c and z
  localparam int FRAC_BITS = 28;
  localparam int C_W       = 32;

  // Iteration limit and colour band edges
  localparam int ITER_MAX  = 80;
  localparam int BAND_LO   = 20;
  localparam int BAND_HI   = 40;
  localparam int CNT_W     = 7;
  localparam int COL_W     = 8;

  // |z| after an update stays below 4 + |c|, so this signed width never wraps
  localparam int Z_W       = ((FRAC_BITS + 2 > C_W - 1) ? FRAC_BITS + 2 : C_W - 1) + 2;
  // Magnitude of a component that has not escaped: below 2
  localparam int MAG_W     = FRAC_BITS + 1;
  // Exact square or cross product of two such magnitudes
  localparam int PROD_W    = 2 * FRAC_BITS + 2;

  // One point in flight through the iteration chain
  typedef struct packed {
    logic signed [Z_W-1:0]   x;
    logic signed [Z_W-1:0]   y;
    logic signed [C_W-1:0]   cr;
    logic signed [C_W-1:0]   ci;
    logic        [CNT_W-1:0] count;
    logic                    done;
  } pt_t;

  // One finished result
  typedef struct packed {
    logic [CNT_W-1:0] iter_count;
    logic [COL_W-1:0] red;
    logic [COL_W-1:0] green;
    logic [COL_W-1:0] blue;
  } res_t;

endpackage

>>> design/mec_point_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one point c of the complex plane.
// No dependencies.
interface mec_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] c_real;
  logic signed [31:0] c_imag;

  modport source (output valid, output c_real, output c_imag, input ready);
  modport sink   (input valid, input c_real, input c_imag, output ready);
endinterface

>>> design/mec_result_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying an iteration count and its colour.
// No dependencies.
interface mec_result_if;
  logic       valid;
  logic       ready;
  logic [6:0] iter_count;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output iter_count, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input iter_count, input red, input green, input blue,
                  output ready);
endinterface

>>> design/mec_iter.sv
`timescale 1ns / 1ps
// One unrolled escape-time iteration z = z*z + c, split into three register stages.
// Depends on mec_pkg.
module mec_iter import mec_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic adv,
  input  logic prev_valid,
  input  pt_t  prev_pt,
  output logic valid,
  output pt_t  pt
);

  typedef struct packed {
    logic [PROD_W-1:0] xx;
    logic [PROD_W-1:0] yy;
    logic [PROD_W-1:0] xy;
    logic              big;
    logic              sdiff;
    pt_t               pt;
  } s1_t;

  typedef struct packed {
    logic signed [PROD_W:0]   re;
    logic signed [PROD_W+1:0] xys;
    logic                     esc;
    pt_t                      pt;
  } s2_t;

  logic           v1, v2;
  s1_t            s1, s1_next;
  s2_t            s2, s2_next;
  pt_t            pt_next;
  logic [Z_W-1:0] ax_full, ay_full;
  logic [MAG_W-1:0] ax, ay;
  logic [PROD_W:0]  mag_sum;
  logic signed [FRAC_BITS+2:0] re_sh;
  logic signed [FRAC_BITS+3:0] xy_sh;

  // Stage 1: magnitudes, out-of-range flag, exact products
  always_comb begin
    ax_full = prev_pt.x[Z_W-1] ? (~prev_pt.x + Z_W'(1)) : prev_pt.x;
    ay_full = prev_pt.y[Z_W-1] ? (~prev_pt.y + Z_W'(1)) : prev_pt.y;
    ax      = ax_full[MAG_W-1:0];
    ay      = ay_full[MAG_W-1:0];
    s1_next.big   = (|ax_full[Z_W-1:MAG_W]) | (|ay_full[Z_W-1:MAG_W]);
    s1_next.sdiff = prev_pt.x[Z_W-1] ^ prev_pt.y[Z_W-1];
    s1_next.xx    = PROD_W'(ax) * PROD_W'(ax);
    s1_next.yy    = PROD_W'(ay) * PROD_W'(ay);
    s1_next.xy    = PROD_W'(ax) * PROD_W'(ay);
    s1_next.pt    = prev_pt;
  end

  // Stage 2: escape test against 4, real part and signed doubled cross term
  always_comb begin
    mag_sum     = {1'b0, s1.xx} + {1'b0, s1.yy};
    s2_next.esc = s1.big | mag_sum[PROD_W];
    s2_next.re  = $signed({1'b0, s1.xx}) - $signed({1'b0, s1.yy});
    s2_next.xys = s1.sdiff ? -$signed({1'b0, s1.xy, 1'b0}) : $signed({1'b0, s1.xy, 1'b0});
    s2_next.pt  = s1.pt;
  end

  // Stage 3: drop fraction bits (floor), add c, advance the count
  always_comb begin
    re_sh   = s2.re[PROD_W:FRAC_BITS];
    xy_sh   = s2.xys[PROD_W+1:FRAC_BITS];
    pt_next = s2.pt;
    if (!s2.pt.done) begin
      if (s2.esc) begin
        pt_next.done = 1'b1;
      end else begin
        pt_next.x     = Z_W'(re_sh) + Z_W'(s2.pt.cr);
        pt_next.y     = Z_W'(xy_sh) + Z_W'(s2.pt.ci);
        pt_next.count = s2.pt.count + CNT_W'(1);
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1    <= prev_valid;
      v2    <= v1;
      valid <= v2;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk) begin
    if (adv) begin
      s1 <= s1_next;
      s2 <= s2_next;
      pt <= pt_next;
    end
  end

endmodule

>>> design/mec_colour.sv
`timescale 1ns / 1ps
// Register stage that maps an iteration count to an RGB colour.
// Depends on mec_pkg.
module mec_colour import mec_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             prev_valid,
  input  logic [CNT_W-1:0] count,
  output logic             valid,
  output res_t             res
);

  res_t        res_next;
  logic [10:0] nw, n2, n3, n6, n8, n12;
  logic [7:0]  half;

  // Map the count to its colour band
  always_comb begin
    nw   = {4'b0, count};
    n2   = nw * 11'd2;
    n3   = nw * 11'd3;
    n6   = nw * 11'd6;
    n8   = nw * 11'd8;
    n12  = nw * 11'd12;
    half = {2'b0, count[CNT_W-1:1]};
    res_next.iter_count = count;
    if (count < CNT_W'(BAND_LO)) begin
      res_next.red   = n8[COL_W-1:0];
      res_next.green = n6[COL_W-1:0];
      res_next.blue  = n12[COL_W-1:0];
    end else if (count < CNT_W'(BAND_HI)) begin
      res_next.red   = n2[COL_W-1:0];
      res_next.green = half;
      res_next.blue  = n6[COL_W-1:0];
    end else if (count == CNT_W'(ITER_MAX)) begin
      res_next.red   = '1;
      res_next.green = '1;
      res_next.blue  = '1;
    end else begin
      res_next.red   = n3[COL_W-1:0];
      res_next.green = half;
      res_next.blue  = n2[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res <= res_next;
    end
  end

endmodule

>>> design/mec_skid.sv
`timescale 1ns / 1ps
// Output register plus one skid entry; produces the pipeline advance enable.
// Depends on mec_pkg and mec_result_if.
module mec_skid import mec_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         prev_valid,
  input  res_t         prev_res,
  output logic         adv,
  mec_result_if.source result
);

  logic out_valid, skid_valid, take;
  res_t main_res, skid_res;

  // Pipeline moves whenever the skid entry is free
  assign adv  = !skid_valid;
  assign take = prev_valid && adv;

  // Refill the output register from skid first, else from the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_res   <= prev_res;
        out_valid  <= take;
      end
    end else if (take) begin
      skid_res   <= prev_res;
      skid_valid <= 1'b1;
    end
  end

  assign result.valid      = out_valid;
  assign result.iter_count = main_res.iter_count;
  assign result.red        = main_res.red;
  assign result.green      = main_res.green;
  assign result.blue       = main_res.blue;

endmodule

>>> design/mandelbrot_escape_colour.sv
`timescale 1ns / 1ps
// Top level of the Mandelbrot escape-time colour block.
// Depends on mec_pkg, mec_point_if, mec_result_if, mec_iter, mec_colour, mec_skid.

// Takes one point c (signed Q4.28) per transaction and returns the number of
// iterations of z = z*z + c run before |z|^2 reaches 4 (at most 80) with its
// RGB colour; white marks a point that never escaped. The block accepts one
// point every cycle while the pipeline is not frozen. The 80 iterations are
// unrolled into 80 units of three register stages each, followed by a colour
// stage and an output register. A point passes through these 242 register
// stages in order, and the output register offers its result to be taken.
// While the result side stalls with the output register full, a one-entry
// skid register takes the next result that leaves the colour stage, and the
// whole pipeline then freezes until the result in the output register is
// taken, so nothing is lost or repeated.
module mandelbrot_escape_colour import mec_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  mec_point_if.sink  point,
  mec_result_if.source result
);

  logic                adv;
  logic [ITER_MAX:0]   chain_valid;
  pt_t  [ITER_MAX:0]   chain_pt;
  logic                col_valid;
  res_t                col_res;

  // Start every point at z = 0 with a zero count
  assign point.ready    = adv;
  assign chain_valid[0] = point.valid;
  assign chain_pt[0]    = {Z_W'(0), Z_W'(0), point.c_real, point.c_imag, CNT_W'(0), 1'b0};

  // Unrolled iteration chain
  for (genvar k = 0; k < ITER_MAX; k++) begin : g_iter
    mec_iter u_iter (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .prev_valid (chain_valid[k]),
      .prev_pt    (chain_pt[k]),
      .valid      (chain_valid[k+1]),
      .pt         (chain_pt[k+1])
    );
  end

  mec_colour u_colour (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .prev_valid (chain_valid[ITER_MAX]),
    .count      (chain_pt[ITER_MAX].count),
    .valid      (col_valid),
    .res        (col_res)
  );

  mec_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .prev_valid (col_valid),
    .prev_res   (col_res),
    .adv        (adv),
    .result     (result)
  );

endmodule

>>> test/mec_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Mandelbrot escape-time colour block: predicts each result
// from the accepted point and compares it with the result channel.
// Depends on mec_pkg, mec_point_if and mec_result_if.
module mec_checker import mec_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mec_point_if  point,
  mec_result_if result,
  output int    errors,
  output int    outstanding
);

  // Colours predicted for points already taken, oldest first
  res_t colour_due[$];

  // Run the escape-time iteration exactly and map the count to its colour
  function automatic res_t escape_colour(input logic signed [C_W-1:0] cr,
                                         input logic signed [C_W-1:0] ci);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] cr_w;
    logic signed [63:0] ci_w;
    logic [63:0]        ax;
    logic [63:0]        ay;
    logic [127:0]       xx;
    logic [127:0]       yy;
    logic [127:0]       re;
    logic [127:0]       xy;
    logic [127:0]       bound;
    logic               escaped;
    int                 n;
    res_t               res;
    cr_w    = {{(64-C_W){cr[C_W-1]}}, cr};
    ci_w    = {{(64-C_W){ci[C_W-1]}}, ci};
    bound   = 128'd1 << (2 * FRAC_BITS + 2);
    x       = '0;
    y       = '0;
    n       = 0;
    escaped = 1'b0;
    while (!escaped && n < ITER_MAX) begin
      ax = x[63] ? (~x + 64'd1) : x;
      ay = y[63] ? (~y + 64'd1) : y;
      xx = {64'd0, ax} * {64'd0, ax};
      yy = {64'd0, ay} * {64'd0, ay};
      // |z|^2 is compared with 4 without rounding
      if (xx + yy >= bound) begin
        escaped = 1'b1;
      end else begin
        re = xx - yy;
        xy = ({64'd0, ax} * {64'd0, ay}) << 1;
        if (x[63] != y[63]) xy = -xy;
        // Arithmetic shift back to the point format floors toward minus infinity
        x  = re[FRAC_BITS +: 64] + cr_w;
        y  = xy[FRAC_BITS +: 64] + ci_w;
        n++;
      end
    end
    res.iter_count = n[CNT_W-1:0];
    if (n < BAND_LO) begin
      res.red   = 8'(8 * n);
      res.green = 8'(6 * n);
      res.blue  = 8'(12 * n);
    end else if (n < BAND_HI) begin
      res.red   = 8'(2 * n);
      res.green = 8'(n / 2);
      res.blue  = 8'(6 * n);
    end else if (n == ITER_MAX) begin
      res.red   = 8'hFF;
      res.green = 8'hFF;
      res.blue  = 8'hFF;
    end else begin
      res.red   = 8'(3 * n);
      res.green = 8'(n / 2);
      res.blue  = 8'(2 * n);
    end
    return res;
  endfunction

  // Predict on each point transaction, compare on each result transaction
  always @(posedge clk) begin : scoreboard
    res_t want;
    res_t got;
    if (rst) begin
      errors      <= 0;
      outstanding <= 0;
    end else begin
      if (point.valid && point.ready)
        colour_due.insert(colour_due.size(), escape_colour(point.c_real, point.c_imag));
      if (result.valid && result.ready) begin
        got.iter_count = result.iter_count;
        got.red        = result.red;
        got.green      = result.green;
        got.blue       = result.blue;
        if (colour_due.size() == 0) begin
          if (errors < 10)
            $display("%0t: result with none pending: count %0d rgb %0d/%0d/%0d", $time,
                     got.iter_count, got.red, got.green, got.blue);
          errors <= errors + 1;
        end else begin
          want = colour_due.pop_front();
          if (got.iter_count != want.iter_count || got.red != want.red ||
              got.green != want.green || got.blue != want.blue) begin
            if (errors < 10)
              $display("%0t: mismatch: expected count %0d rgb %0d/%0d/%0d, got count %0d rgb %0d/%0d/%0d",
                       $time, want.iter_count, want.red, want.green, want.blue,
                       got.iter_count, got.red, got.green, got.blue);
            errors <= errors + 1;
          end
        end
      end
      outstanding <= colour_due.size();
    end
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top of the Mandelbrot escape-time colour test: drives points, throttles results,
// and reports the verdict. Depends on mec_pkg, both channel interfaces, the block
// and mec_checker.
module testbench import mec_pkg::*;;

  localparam int ONE       = 1 << FRAC_BITS;
  localparam int LATENCY   = 242;
  localparam int QUIET_MAX = 4000;
  localparam int PER_PHASE = 217;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   src_idle_pct;
  int   sink_idle_pct;
  int   errors;
  int   outstanding;
  int   quiet;

  mec_point_if  point_ch();
  mec_result_if result_ch();

  mandelbrot_escape_colour u_top (
    .clk    (clk),
    .rst    (rst),
    .point  (point_ch),
    .result (result_ch)
  );

  mec_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .point       (point_ch),
    .result      (result_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // End the run when no transaction happens for too long
  always @(posedge clk) begin
    if (rst || (point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_MAX) begin
        $display("FAIL mandelbrot_escape_colour");
        $finish;
      end
    end
  end

  // Stall the result side at the current rate
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
    end
  end

  // Offer one point, idling first at the current rate; return at a falling edge
  task automatic send_point(input logic signed [31:0] re, input logic signed [31:0] im);
    while ($urandom_range(99, 0) < src_idle_pct) begin
      point_ch.valid <= 1'b0;
      @(negedge clk);
    end
    point_ch.valid  <= 1'b1;
    point_ch.c_real <= re;
    point_ch.c_imag <= im;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold the point side until every predicted result has come back
  task automatic hold_until_drained();
    point_ch.valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // Random point: in part near the set boundary so that every colour band shows up
  task automatic send_random_point();
    int re;
    int im;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      // Box around the whole set
      re = int'($urandom_range(3 * ONE, 0)) - 9 * (ONE / 4);
      im = int'($urandom_range(3 * ONE, 0)) - 3 * (ONE / 2);
    end else if (pick < 60) begin
      // Just right of the cusp: slow escape along the real axis
      re = ONE / 4 + int'($urandom_range(ONE / 32, 0));
      im = int'($urandom_range(1 << 17, 0)) - (1 << 16);
    end else if (pick < 75) begin
      // Through the neck between the main cardioid and the period-2 bulb
      re = -3 * (ONE / 4) + int'($urandom_range(1 << 17, 0)) - (1 << 16);
      im = int'($urandom_range(ONE / 8, ONE / 32));
      if ($urandom_range(1, 0)) im = -im;
    end else begin
      // Any bit pattern
      re = int'($urandom());
      im = int'($urandom());
    end
    send_point(re, im);
  endtask

  task automatic run_random(input int count);
    repeat (count) send_random_point();
  endtask

  initial begin
    point_ch.valid  <= 1'b0;
    point_ch.c_real <= '0;
    point_ch.c_imag <= '0;
    src_idle_pct  = 20;
    sink_idle_pct = 61;

    // Apply reset, then release it
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed points: field extremes, the iteration limit, each colour band
    send_point(32'sd0, 32'sd0);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_point(32'sh80000000, 32'sh7FFFFFFF);
    send_point(32'sh7FFFFFFF, 32'sh80000000);
    send_point(32'sh80000000, 32'sd0);
    send_point(32'sd0, 32'sh7FFFFFFF);
    send_point(-2 * ONE, 0);
    send_point(-2 * ONE - 1, 0);
    send_point(2 * ONE, 2 * ONE);
    send_point(ONE / 4, 0);
    send_point(ONE / 4 + ONE / 256, 0);
    send_point(ONE / 4 + ONE / 64, 0);
    send_point(ONE / 4 + ONE / 16, 0);
    send_point(ONE / 2, 0);
    send_point(-ONE, 0);
    send_point(0, ONE);
    send_point(-3 * (ONE / 4), ONE / 16);
    send_point(-3 * (ONE / 4), ONE / 10);
    send_point(-1, -1);
    send_point(1, 1);

    // Pause the sender until the pipeline is empty
    hold_until_drained();

    run_random(PER_PHASE);
    hold_until_drained();
    src_idle_pct  = 61;
    sink_idle_pct = 20;
    run_random(PER_PHASE);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(PER_PHASE - 1);

    // Drain, then watch for stray results for longer than the pipeline is deep
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0)
      $display("PASS mandelbrot_escape_colour");
    else
      $display("FAIL mandelbrot_escape_colour");
    $finish;
  end

endmodule
